[src/gb5_pkg.sv]
// ============================================================================
// gb5_pkg
// shared constants, kernel weights and types of the 5x5 gaussian blur core
// ============================================================================
`default_nettype none

package gb5_pkg;

    // image geometry
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MIN_DIM     = 5;
    localparam int DIM_W       = 11;
    localparam int POS_W       = 10;
    localparam int PIX_W       = 8;

    // line store: one word per column holds the four previous rows
    localparam int LINES       = 4;
    localparam int LINE_WORD_W = PIX_W * LINES;
    localparam int LADDR_W     = $clog2(MAX_WIDTH);

    // kernel
    localparam int KDIM        = 5;
    localparam int KHALF       = KDIM / 2;
    localparam int KSUM        = 330;
    localparam int KW_CORNER   = 1;
    localparam int KW_EDGE     = 4;
    localparam int KW_SIDE     = 7;
    localparam int KW_INNER    = 20;
    localparam int KW_CROSS    = 33;
    localparam int KW_CENTER   = 54;
    localparam int SUM_W       = 17;

    // divide by KSUM as multiply by reciprocal plus one correction step
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = (2 ** RECIP_SHIFT) / KSUM;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int Q0_W        = PROD_W - RECIP_SHIFT;

    // group sums: four pixels or eight pixels
    localparam int GRP4_W      = PIX_W + 2;
    localparam int GRP8_W      = PIX_W + 3;

    // output queue
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = FIFO_AW + 1;

    // configuration registers
    localparam int CFG_IDX_W   = 4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
    localparam logic [DIM_W-1:0]     WIDTH_RESET      = DIM_W'(640);
    localparam logic [DIM_W-1:0]     HEIGHT_RESET     = DIM_W'(480);

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             frame_end;
    } gb5_tag_t;

    typedef struct packed {
        logic [GRP4_W-1:0] corner;
        logic [GRP8_W-1:0] edge4;
        logic [GRP4_W-1:0] side;
        logic [GRP4_W-1:0] inner;
        logic [GRP4_W-1:0] cross4;
        logic [PIX_W-1:0]  center;
    } gb5_groups_t;

    typedef struct packed {
        logic [PIX_W-1:0] filtered;
        gb5_tag_t         tag;
    } gb5_result_t;

endpackage

`default_nettype wire

[src/gb5_line_mem.sv]
// ============================================================================
// gb5_line_mem
// line store ram, one word of four stacked rows per column, registered read
// ============================================================================
`default_nettype none

module gb5_line_mem (
    input  wire logic                          clk,
    input  wire logic [gb5_pkg::LADDR_W-1:0]   rd_addr,
    output logic      [gb5_pkg::LINE_WORD_W-1:0] rd_data,
    input  wire logic                          wr_en,
    input  wire logic [gb5_pkg::LADDR_W-1:0]   wr_addr,
    input  wire logic [gb5_pkg::LINE_WORD_W-1:0] wr_data
);
    import gb5_pkg::*;

    logic [LINE_WORD_W-1:0] mem [MAX_WIDTH];

    // read returns old data on a same-address write
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[src/gb5_window.sv]
// ============================================================================
// gb5_window
// line store write-back with forwarding, 5x5 window and symmetric group sums
// ============================================================================
`default_nettype none

module gb5_window (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            a_valid,
    input  wire logic                            a_emit,
    input  wire logic [gb5_pkg::PIX_W-1:0]       a_px,
    input  wire logic [gb5_pkg::LADDR_W-1:0]     a_col,
    input  wire gb5_pkg::gb5_tag_t               a_tag,
    input  wire logic [gb5_pkg::LINE_WORD_W-1:0] rd_data,
    output logic                                 wr_en,
    output logic      [gb5_pkg::LADDR_W-1:0]     wr_addr,
    output logic      [gb5_pkg::LINE_WORD_W-1:0] wr_data,
    output logic                                 grp_valid,
    output gb5_pkg::gb5_groups_t                 grp,
    output gb5_pkg::gb5_tag_t                    grp_tag,
    output logic      [1:0]                      busy_count
);
    import gb5_pkg::*;

    logic                   fwd_valid_reg;
    logic [LADDR_W-1:0]     fwd_addr_reg;
    logic [LINE_WORD_W-1:0] fwd_data_reg;
    logic [LINE_WORD_W-1:0] stored;
    logic [KDIM-1:0][PIX_W-1:0] new_col;

    logic [PIX_W-1:0]       win_reg [KDIM][KDIM];
    logic                   b_valid_reg;
    gb5_tag_t               b_tag_reg;

    logic                   grp_valid_reg;
    gb5_groups_t            grp_reg;
    gb5_groups_t            grp_next;
    gb5_tag_t               grp_tag_reg;

    // previous write lands on the same edge as this read was taken
    assign stored  = (fwd_valid_reg && (fwd_addr_reg == a_col)) ? fwd_data_reg : rd_data;
    assign new_col = {a_px, stored};

    // every row moves up one slot, the new pixel goes on top
    assign wr_en   = a_valid;
    assign wr_addr = a_col;
    assign wr_data = {a_px, stored[LINE_WORD_W-1:PIX_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
            b_valid_reg   <= 1'b0;
            grp_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= a_valid;
            b_valid_reg   <= a_valid & a_emit;
            grp_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr_data;
        b_tag_reg    <= a_tag;
        grp_reg      <= grp_next;
        grp_tag_reg  <= b_tag_reg;
        if (a_valid)
        begin
            for (int i = 0; i < KDIM; i++)
            begin
                for (int j = 0; j < KDIM - 1; j++)
                begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
                win_reg[i][KDIM-1] <= new_col[i];
            end
        end
    end

    // pixels sharing one kernel weight are summed first
    always_comb
    begin
        grp_next.corner = GRP4_W'(win_reg[0][0]) + GRP4_W'(win_reg[0][4])
                        + GRP4_W'(win_reg[4][0]) + GRP4_W'(win_reg[4][4]);
        grp_next.edge4  = GRP8_W'(win_reg[0][1]) + GRP8_W'(win_reg[0][3])
                        + GRP8_W'(win_reg[1][0]) + GRP8_W'(win_reg[1][4])
                        + GRP8_W'(win_reg[3][0]) + GRP8_W'(win_reg[3][4])
                        + GRP8_W'(win_reg[4][1]) + GRP8_W'(win_reg[4][3]);
        grp_next.side   = GRP4_W'(win_reg[0][2]) + GRP4_W'(win_reg[2][0])
                        + GRP4_W'(win_reg[2][4]) + GRP4_W'(win_reg[4][2]);
        grp_next.inner  = GRP4_W'(win_reg[1][1]) + GRP4_W'(win_reg[1][3])
                        + GRP4_W'(win_reg[3][1]) + GRP4_W'(win_reg[3][3]);
        grp_next.cross4 = GRP4_W'(win_reg[1][2]) + GRP4_W'(win_reg[2][1])
                        + GRP4_W'(win_reg[2][3]) + GRP4_W'(win_reg[3][2]);
        grp_next.center = win_reg[2][2];
    end

    assign grp_valid  = grp_valid_reg;
    assign grp        = grp_reg;
    assign grp_tag    = grp_tag_reg;
    assign busy_count = {1'b0, b_valid_reg} + {1'b0, grp_valid_reg};

endmodule

`default_nettype wire

[src/gb5_kernel.sv]
// ============================================================================
// gb5_kernel
// weighted group sum and truncating divide by the kernel total
// ============================================================================
`default_nettype none

module gb5_kernel (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 grp_valid,
    input  wire gb5_pkg::gb5_groups_t grp,
    input  wire gb5_pkg::gb5_tag_t    grp_tag,
    output logic                      res_valid,
    output gb5_pkg::gb5_result_t      res,
    output logic      [1:0]           busy_count
);
    import gb5_pkg::*;

    logic              d_valid_reg;
    logic [SUM_W-1:0]  d_sum_reg;
    logic [SUM_W-1:0]  d_sum_next;
    gb5_tag_t          d_tag_reg;

    logic              e_valid_reg;
    logic [PROD_W-1:0] e_prod_reg;
    logic [SUM_W-1:0]  e_sum_reg;
    gb5_tag_t          e_tag_reg;

    logic [Q0_W-1:0]   q0;
    logic [SUM_W-1:0]  rem;
    logic [Q0_W-1:0]   q;

    // constant weights reduce to shifts and adds
    assign d_sum_next = SUM_W'(grp.corner) * SUM_W'(KW_CORNER)
                      + SUM_W'(grp.edge4)  * SUM_W'(KW_EDGE)
                      + SUM_W'(grp.side)   * SUM_W'(KW_SIDE)
                      + SUM_W'(grp.inner)  * SUM_W'(KW_INNER)
                      + SUM_W'(grp.cross4) * SUM_W'(KW_CROSS)
                      + SUM_W'(grp.center) * SUM_W'(KW_CENTER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= grp_valid;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_sum_reg  <= d_sum_next;
        d_tag_reg  <= grp_tag;
        e_prod_reg <= PROD_W'(d_sum_reg) * PROD_W'(RECIP);
        e_sum_reg  <= d_sum_reg;
        e_tag_reg  <= d_tag_reg;
    end

    // reciprocal estimate is exact or one low
    assign q0  = e_prod_reg[PROD_W-1:RECIP_SHIFT];
    assign rem = e_sum_reg - SUM_W'(q0) * SUM_W'(KSUM);
    assign q   = (rem >= SUM_W'(KSUM)) ? Q0_W'(q0 + Q0_W'(1)) : q0;

    assign res_valid    = e_valid_reg;
    assign res.filtered = q[PIX_W-1:0];
    assign res.tag      = e_tag_reg;
    assign busy_count   = {1'b0, d_valid_reg} + {1'b0, e_valid_reg};

endmodule

`default_nettype wire

[src/gb5_out_fifo.sv]
// ============================================================================
// gb5_out_fifo
// result queue between the non-stalling pipeline and the output channel
// ============================================================================
`default_nettype none

module gb5_out_fifo (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         push,
    input  wire gb5_pkg::gb5_result_t         push_data,
    input  wire logic                         pop,
    output logic                              head_valid,
    output gb5_pkg::gb5_result_t              head_data,
    output logic      [gb5_pkg::FIFO_CW-1:0]  count
);
    import gb5_pkg::*;

    gb5_result_t        fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;
    logic               do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign count_next = count_reg + FIFO_CW'(push) - FIFO_CW'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_data  = fifo_mem[rd_ptr_reg];
    assign count      = count_reg;

endmodule

`default_nettype wire

[src/gaussian_blur_5x5_core.sv]
// ============================================================================
// gaussian_blur_5x5_core
// 5x5 gaussian blur over a raster stream of 8-bit grayscale pixels
//
// input channel: pixel and frame_start under in_valid/in_ready; frame_start
//   puts the position back to row 0, column 0 before the pixel is taken
// output channel: filtered, out_row, out_col, frame_end under
//   out_valid/out_ready, one request for each pixel whose 5x5 window lies
//   inside the image, tagged with the window centre
// config channel: cfg_index/cfg_data under cfg_valid/cfg_ready, always
//   ready; index 0 is image width, index 1 image height, others ignored
// throughput: one pixel per clock while in_ready is high, bounded by the
//   line ram taking one read and one write-back per cycle, with a one-entry
//   forward for back-to-back access to the same column
// path: stage a, window, group, sum and product registers, then the queue
// stall: the pipeline itself never stops; an 8-entry result queue absorbs
//   a stalled receiver and in_ready drops once queue plus in-flight pixels
//   would fill it
// reset: position and valids clear at once, config goes to 640 by 480; the
//   line ram needs no clearing, results only read rows written this frame
// ============================================================================
`default_nettype none

module gaussian_blur_5x5_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // pixel requests
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [gb5_pkg::PIX_W-1:0]      pixel,
    input  wire logic                           frame_start,
    // result requests
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [gb5_pkg::PIX_W-1:0]      filtered,
    output logic      [gb5_pkg::POS_W-1:0]      out_row,
    output logic      [gb5_pkg::POS_W-1:0]      out_col,
    output logic                                frame_end,
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [gb5_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gb5_pkg::DIM_W-1:0]      cfg_data
);
    import gb5_pkg::*;

    // config registers
    logic [DIM_W-1:0]       width_reg;
    logic [DIM_W-1:0]       height_reg;
    logic [DIM_W-1:0]       eff_width;
    logic [DIM_W-1:0]       eff_height;

    // raster position
    logic [POS_W-1:0]       row_count_reg;
    logic [POS_W-1:0]       row_count_next;
    logic [POS_W-1:0]       col_count_reg;
    logic [POS_W-1:0]       col_count_next;
    logic [POS_W-1:0]       cur_row;
    logic [POS_W-1:0]       cur_col;
    logic                   col_last;
    logic                   row_last;
    logic                   emit;
    gb5_tag_t               cur_tag;
    logic                   in_accept;

    // stage a: line ram read in flight
    logic                   a_valid_reg;
    logic                   a_emit_reg;
    logic [PIX_W-1:0]       a_px_reg;
    logic [LADDR_W-1:0]     a_col_reg;
    gb5_tag_t               a_tag_reg;

    // line ram
    logic [LINE_WORD_W-1:0] rd_data;
    logic                   wr_en;
    logic [LADDR_W-1:0]     wr_addr;
    logic [LINE_WORD_W-1:0] wr_data;

    // window and kernel
    logic                   grp_valid;
    gb5_groups_t            grp;
    gb5_tag_t               grp_tag;
    logic [1:0]             win_busy;
    logic                   res_valid;
    gb5_result_t            res;
    logic [1:0]             kern_busy;

    // result queue and credit
    gb5_result_t            head_data;
    logic [FIFO_CW-1:0]     fifo_count;
    logic [2:0]             inflight;
    logic [FIFO_CW:0]       occupancy;

    // --------------------------------------------------------------------
    // configuration
    // --------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // out-of-range dimensions saturate to the supported range
    always_comb
    begin
        priority if (width_reg < DIM_W'(MIN_DIM))
            eff_width = DIM_W'(MIN_DIM);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            eff_width = DIM_W'(MAX_WIDTH);
        else
            eff_width = width_reg;

        priority if (height_reg < DIM_W'(MIN_DIM))
            eff_height = DIM_W'(MIN_DIM);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            eff_height = DIM_W'(MAX_HEIGHT);
        else
            eff_height = height_reg;
    end

    // --------------------------------------------------------------------
    // position tracking at accept
    // --------------------------------------------------------------------
    assign in_accept = in_valid && in_ready;
    assign cur_row   = frame_start ? '0 : row_count_reg;
    assign cur_col   = frame_start ? '0 : col_count_reg;
    assign col_last  = ((DIM_W'(cur_col) + DIM_W'(1)) >= eff_width);
    assign row_last  = ((DIM_W'(cur_row) + DIM_W'(1)) >= eff_height);

    // window complete once four earlier rows and columns are in
    assign emit = (cur_row >= POS_W'(KDIM - 1)) && (cur_col >= POS_W'(KDIM - 1));

    assign cur_tag.row       = cur_row - POS_W'(KHALF);
    assign cur_tag.col       = cur_col - POS_W'(KHALF);
    assign cur_tag.frame_end = row_last && col_last;

    always_comb
    begin
        if (col_last)
        begin
            col_count_next = '0;
            row_count_next = row_last ? '0 : POS_W'(cur_row + POS_W'(1));
        end
        else
        begin
            col_count_next = POS_W'(cur_col + POS_W'(1));
            row_count_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            a_valid_reg   <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_accept;
            if (in_accept)
            begin
                row_count_reg <= row_count_next;
                col_count_reg <= col_count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_emit_reg <= emit;
        a_px_reg   <= pixel;
        a_col_reg  <= cur_col[LADDR_W-1:0];
        a_tag_reg  <= cur_tag;
    end

    // --------------------------------------------------------------------
    // datapath
    // --------------------------------------------------------------------
    gb5_line_mem u_line_mem (
        .clk     (clk),
        .rd_addr (cur_col[LADDR_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    gb5_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .a_valid    (a_valid_reg),
        .a_emit     (a_emit_reg),
        .a_px       (a_px_reg),
        .a_col      (a_col_reg),
        .a_tag      (a_tag_reg),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .grp_valid  (grp_valid),
        .grp        (grp),
        .grp_tag    (grp_tag),
        .busy_count (win_busy)
    );

    gb5_kernel u_kernel (
        .clk        (clk),
        .rst_n      (rst_n),
        .grp_valid  (grp_valid),
        .grp        (grp),
        .grp_tag    (grp_tag),
        .res_valid  (res_valid),
        .res        (res),
        .busy_count (kern_busy)
    );

    gb5_out_fifo u_out_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .pop        (out_ready),
        .head_valid (out_valid),
        .head_data  (head_data),
        .count      (fifo_count)
    );

    // every pixel in flight may still need a queue slot
    assign inflight  = 3'(a_valid_reg) + 3'(win_busy) + 3'(kern_busy);
    assign occupancy = (FIFO_CW + 1)'(fifo_count) + (FIFO_CW + 1)'(inflight);
    assign in_ready  = (occupancy < (FIFO_CW + 1)'(FIFO_DEPTH));

    assign filtered  = head_data.filtered;
    assign out_row   = head_data.tag.row;
    assign out_col   = head_data.tag.col;
    assign frame_end = head_data.tag.frame_end;

    // --------------------------------------------------------------------
    // assertions
    // --------------------------------------------------------------------
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= (FIFO_CW + 1)'(FIFO_DEPTH))
        else $error("result queue credit exceeded");

    a_emit_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && a_emit_reg) |-> ##4 res_valid)
        else $error("complete window did not reach the result queue");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> $past(a_valid_reg && a_emit_reg, 4))
        else $error("result without a matching complete window");

    a_ready_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (fifo_count != '0))
        else $error("input held off with an empty result queue");

endmodule

`default_nettype wire

[verif/tb_gaussian_blur_5x5_core.sv]
// ============================================================================
// tb_gaussian_blur_5x5_core
// self-checking bench for the 5x5 gaussian blur core: a clocked driver feeds
// pixel requests from a queue, a behavioral blur model predicts each result
// at the moment its pixel is accepted, and a clocked monitor compares every
// result request field by field, in order, under random idling on both sides
// ============================================================================
`default_nettype none

module tb_gaussian_blur_5x5_core;
    timeunit 1ns;
    timeprecision 1ps;

    import gb5_pkg::*;

    // register indexes the core has to ignore
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(15);

    localparam int unsigned BLUR_NORM    = 330;   // sum of all kernel taps
    localparam int          NO_SOF       = -1;    // no frame start in a burst
    localparam int unsigned DRAIN_CYCLES = 10;    // pipeline is 5 deep
    localparam int unsigned RAND_PHASES  = 6;
    localparam int unsigned RAND_ITEMS   = 540;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned SAT_BURST    = 150;   // pixels per saturated-geometry run

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             sof;
    } pix_req_t;

    typedef enum logic [1:0] {PIX_NOISE, PIX_FLAT, PIX_BINARY} pix_style_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic [PIX_W-1:0]     pixel       = '0;
    logic                 frame_start = 1'b0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic [PIX_W-1:0]     filtered;
    logic [POS_W-1:0]     out_row;
    logic [POS_W-1:0]     out_col;
    logic                 frame_end;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [DIM_W-1:0]     cfg_data    = '0;

    gaussian_blur_5x5_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .filtered    (filtered),
        .out_row     (out_row),
        .out_col     (out_col),
        .frame_end   (frame_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin : clock_gen
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // blur model: its own copy of the line history, the window, the raster
    // position and the two dimension registers
    // ------------------------------------------------------------------------
    logic [PIX_W-1:0] line_hist [4][MAX_WIDTH];   // per column, rows r-4..r-1
    logic [PIX_W-1:0] blur_win [5][5];            // [row][col], col 4 newest
    int unsigned      row_pos;
    int unsigned      col_pos;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    gb5_result_t      blur_expect [$];            // results still owed by the core

    pix_req_t         pix_queue [$];              // pixels waiting for the driver
    int unsigned      tx_idle_pct = 0;
    int unsigned      rx_idle_pct = 0;
    int unsigned      rx_hold_req = 0;            // asks the monitor for a long hold
    int               fail_count  = 0;

    // register value saturated into the usable range
    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // kernel tap by distance from the centre, symmetric in both axes
    function automatic int unsigned tap_weight(input int i, input int j);
        int di;
        int dj;
        int lo;
        int hi;
        di = (i > 2) ? i - 2 : 2 - i;
        dj = (j > 2) ? j - 2 : 2 - j;
        lo = (di < dj) ? di : dj;
        hi = (di < dj) ? dj : di;
        if (lo == 0)
            return (hi == 0) ? 54 : (hi == 1) ? 33 : 7;
        if (lo == 1)
            return (hi == 1) ? 20 : 4;
        return 1;
    endfunction

    // one accepted pixel: update history and window, queue a result when the
    // whole window lies inside the image, then advance the raster position
    function automatic void blur_step(input logic [PIX_W-1:0] px, input logic sof);
        int unsigned      w;
        int unsigned      h;
        int unsigned      r;
        int unsigned      c;
        int unsigned      acc;
        logic [PIX_W-1:0] column [5];
        gb5_result_t      res;
        w = eff_dim(width_reg, MAX_WIDTH);
        h = eff_dim(height_reg, MAX_HEIGHT);
        if (sof)
        begin
            row_pos = 0;
            col_pos = 0;
        end
        r = row_pos;
        c = col_pos;
        for (int i = 0; i < 4; i++)
            column[i] = line_hist[i][c];
        column[4] = px;
        for (int i = 0; i < 4; i++)
            line_hist[i][c] = column[i + 1];
        for (int i = 0; i < 5; i++)
        begin
            for (int j = 0; j < 4; j++)
                blur_win[i][j] = blur_win[i][j + 1];
            blur_win[i][4] = column[i];
        end
        if (r >= 4 && c >= 4)
        begin
            acc = 0;
            for (int i = 0; i < 5; i++)
                for (int j = 0; j < 5; j++)
                    acc += blur_win[i][j] * tap_weight(i, j);
            res.filtered      = PIX_W'(acc / BLUR_NORM);
            res.tag.row       = POS_W'(r - 2);
            res.tag.col       = POS_W'(c - 2);
            res.tag.frame_end = (r + 1 >= h) && (c + 1 >= w);
            blur_expect.push_back(res);
        end
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos++;
    endfunction

    function automatic void compare_field(input string name, input logic [POS_W-1:0] want,
                                          input logic [POS_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result();
        gb5_result_t want;
        if (blur_expect.size() == 0)
        begin
            $error("result at row %0d col %0d with none expected", out_row, out_col);
            fail_count++;
            return;
        end
        want = blur_expect.pop_front();
        compare_field("filtered", POS_W'(want.filtered), POS_W'(filtered));
        compare_field("out_row", want.tag.row, out_row);
        compare_field("out_col", want.tag.col, out_col);
        compare_field("frame_end", POS_W'(want.tag.frame_end), POS_W'(frame_end));
    endfunction

    // ------------------------------------------------------------------------
    // pixel driver: takes the next request from the queue whenever the slot is
    // free, sometimes inserting an idle burst instead
    // ------------------------------------------------------------------------
    int unsigned tx_gap_left;

    always @(posedge clk or negedge rst_n)
    begin : pixel_driver
        pix_req_t nxt;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            pixel       <= '0;
            frame_start <= 1'b0;
            tx_gap_left = 0;
        end
        else
        begin
            // the model sees the pixel exactly when the core takes it
            if (in_valid && in_ready)
                blur_step(pixel, frame_start);
            if (!in_valid || in_ready)
            begin
                if (tx_gap_left != 0)
                begin
                    tx_gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pix_queue.size() != 0 && tx_idle_pct != 0 &&
                         $urandom_range(99) < tx_idle_pct)
                begin
                    tx_gap_left = $urandom_range(10, 0);
                    in_valid <= 1'b0;
                end
                else if (pix_queue.size() != 0)
                begin
                    nxt = pix_queue.pop_front();
                    in_valid    <= 1'b1;
                    pixel       <= nxt.pixel;
                    frame_start <= nxt.sof;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor: checks each accepted result, and throttles out_ready with
    // idle bursts or one long hold that backs the core up into its input
    // ------------------------------------------------------------------------
    int unsigned rx_gap_left;
    int unsigned rx_hold_left;

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_gap_left  = 0;
            rx_hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (rx_hold_req != 0)
            begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left != 0)
            begin
                rx_hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_gap_left != 0)
            begin
                rx_gap_left--;
                out_ready <= 1'b0;
            end
            else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct)
            begin
                rx_gap_left = $urandom_range(10, 0);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val;
        else if (idx == REG_IMAGE_HEIGHT)
            height_reg = val;
    endtask

    // nothing queued, nothing in flight, nothing owed, then let the pipe empty
    task automatic wait_idle();
        @(negedge clk);
        while (pix_queue.size() != 0 || in_valid || blur_expect.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // new dimensions in random order, then the idling of the phase
    task automatic start_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                               input int unsigned tx_pct, input int unsigned rx_pct);
        if ($urandom_range(1))
        begin
            cfg_write(REG_IMAGE_WIDTH, w);
            cfg_write(REG_IMAGE_HEIGHT, h);
        end
        else
        begin
            cfg_write(REG_IMAGE_HEIGHT, h);
            cfg_write(REG_IMAGE_WIDTH, w);
        end
        @(negedge clk);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    function automatic logic [PIX_W-1:0] random_level();
        if ($urandom_range(3) == 0)
            return $urandom_range(1) ? 8'hff : 8'h00;
        return PIX_W'($urandom);
    endfunction

    function automatic int unsigned random_idle();
        case ($urandom_range(2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    // queue a burst of pixels; sof_at marks which one carries frame start
    task automatic push_pixels(input int count, input int sof_at, input pix_style_t style,
                               input logic [PIX_W-1:0] level);
        pix_req_t req;
        for (int k = 0; k < count; k++)
        begin
            case (style)
                PIX_FLAT:   req.pixel = level;
                PIX_BINARY: req.pixel = $urandom_range(1) ? 8'hff : 8'h00;
                default:    req.pixel = PIX_W'($urandom);
            endcase
            req.sof = (k == sof_at);
            pix_queue.push_back(req);
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        int               n;
        int               count;
        int               frame_px;
        int               sof_at;
        int               mode;
        bit               fresh;
        bit               last;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < MAX_WIDTH; j++)
                line_hist[i][j] = '0;
        for (int i = 0; i < 5; i++)
            for (int j = 0; j < 5; j++)
                blur_win[i][j] = '0;
        row_pos    = 0;
        col_pos    = 0;
        width_reg  = WIDTH_RESET;
        height_reg = HEIGHT_RESET;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        // smallest frame, height saturated up from 4, all-white window;
        // writes to spare indexes must leave the geometry alone
        start_phase(11'd5, 11'd4, 0, 0);
        cfg_write(REG_SPARE_LO, 11'd7);
        cfg_write(REG_SPARE_HI, 11'd2047);
        @(negedge clk);
        push_pixels(25, 0, PIX_FLAT, 8'hff);
        wait_idle();

        // shrink the image while the position sits past the new limits, so
        // both row and column wrap after the next pixel; then grow height
        start_phase(11'd9, 11'd8, 10, 10);
        push_pixels(61, 0, PIX_NOISE, 8'h00);
        wait_idle();
        cfg_write(REG_IMAGE_WIDTH, 11'd6);
        cfg_write(REG_IMAGE_HEIGHT, 11'd5);
        @(negedge clk);
        push_pixels(40, NO_SOF, PIX_NOISE, 8'h00);
        wait_idle();
        cfg_write(REG_IMAGE_HEIGHT, 11'd9);
        @(negedge clk);
        push_pixels(50, NO_SOF, PIX_BINARY, 8'h00);
        wait_idle();

        // receiver goes silent while the sender keeps offering: the result
        // queue fills and in_ready has to drop until the hold ends
        start_phase(11'd12, 11'd12, 0, 0);
        rx_hold_req = LONG_HOLD;
        push_pixels(144, 0, PIX_NOISE, 8'h00);
        push_pixels(144, NO_SOF, PIX_NOISE, 8'h00);
        wait_idle();

        // tall narrow frame, width saturated up from 0
        start_phase(11'd0, 11'd1024, 5, 5);
        push_pixels(SAT_BURST, 0, PIX_NOISE, 8'h00);
        wait_idle();

        // wide frame, width saturated down from the register maximum
        start_phase(11'd2047, 11'd5, 5, 5);
        push_pixels(SAT_BURST, 0, PIX_NOISE, 8'h00);
        wait_idle();

        // random geometries: mostly whole frames back to back, relying on the
        // automatic wrap, with some cut short or restarted part way through
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            last = (phase == RAND_PHASES - 1);
            case ($urandom_range(9))
                0:       w = DIM_W'($urandom_range(4, 0));
                1:       w = DIM_W'($urandom_range(40, 17));
                default: w = DIM_W'($urandom_range(16, 5));
            endcase
            h = ($urandom_range(5) == 0) ? DIM_W'($urandom_range(4, 0))
                                         : DIM_W'($urandom_range(12, 5));
            start_phase(w, h, last ? 0 : random_idle(), last ? 0 : random_idle());
            frame_px = eff_dim(w, MAX_WIDTH) * eff_dim(h, MAX_HEIGHT);
            fresh    = 1'b1;
            n        = 0;
            while (n < RAND_ITEMS / RAND_PHASES)
            begin
                mode   = $urandom_range(9);
                sof_at = (fresh || $urandom_range(1)) ? 0 : NO_SOF;
                count  = frame_px;
                if (mode == 0)
                begin
                    // truncated frame, the next one restarts with frame start
                    count = $urandom_range(frame_px - 1, 1);
                    fresh = 1'b1;
                end
                else if (mode == 1 && !fresh)
                begin
                    // frame start lands in the middle of a frame
                    sof_at = $urandom_range(frame_px - 1, 1);
                    fresh  = 1'b1;
                end
                else
                    fresh = 1'b0;
                push_pixels(count, sof_at, pix_style_t'($urandom_range(2)), random_level());
                n += count;
            end
            wait_idle();
        end

        if (fail_count == 0)
            $display("gaussian_blur_5x5_core regression: pass");
        else
            $display("gaussian_blur_5x5_core regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        #20ms;
        $display("gaussian_blur_5x5_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
